// ===== rtl/core/xorshift128plus_random_unit_top_defines.svh =====
// Assertion macros shared by the random unit RTL.
`ifndef XORSHIFT128PLUS_RANDOM_UNIT_TOP_DEFINES_SVH
`define XORSHIFT128PLUS_RANDOM_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define XRU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xru assertion failed");
`define XRU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xru assertion failed");
`else
`define XRU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define XRU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/xru_pkg.sv =====
// Shared widths, opcodes, constants and types of the random unit.
package xru_pkg;

   localparam int WORD_W      = 64;
   localparam int HALF_W      = 32;
   localparam int OPCODE_W    = 4;
   localparam int PROB_W      = 54;
   localparam int MUL_DIGIT_W = 4;

   localparam logic [OPCODE_W-1:0] OP_RAW       = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_RANGE_U32 = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_RANGE_U64 = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_RANGE_I32 = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_RANGE_I64 = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_FRACTION  = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_CHANCE    = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_IDENT     = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_BIT       = 4'd8;

   localparam logic [WORD_W-1:0] SEED_RESET     = 64'd1;
   localparam logic [WORD_W-1:0] GOLDEN_GAMMA   = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] GOLDEN_GAMMA_2 = 64'h3c6e_f372_fe94_f82a;
   localparam logic [WORD_W-1:0] MIX_MUL_1      = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL_2      = 64'h94d0_49bb_1331_11eb;

   localparam int MIX_SHR_1 = 30;
   localparam int MIX_SHR_2 = 27;
   localparam int MIX_SHR_3 = 31;
   localparam int XS_SHL    = 23;
   localparam int XS_SHR_1  = 17;
   localparam int XS_SHR_2  = 26;
   localparam int FRAC_SHR  = 11;

   typedef struct packed {
      logic step;
      logic load_a;
      logic load_b;
   } gen_ctrl_type;

endpackage

// ===== rtl/core/xru_req_if.sv =====
// Request channel carrying one opcode with its operands per beat.
interface xru_req_if;
   logic                           valid;
   logic                           ready;
   logic [xru_pkg::OPCODE_W-1:0]   opcode;
   logic [xru_pkg::WORD_W-1:0]     low_bound;
   logic [xru_pkg::WORD_W-1:0]     high_bound;
   logic [xru_pkg::PROB_W-1:0]     probability;

   modport source (output valid, output opcode, output low_bound, output high_bound,
                   output probability, input ready);
   modport sink (input valid, input opcode, input low_bound, input high_bound,
                 input probability, output ready);
endinterface

// ===== rtl/core/xru_rsp_if.sv =====
// Response channel carrying one 64-bit result per beat.
interface xru_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [xru_pkg::WORD_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/core/xru_csr_if.sv =====
// Seed register write channel.
interface xru_csr_if;
   logic                       valid;
   logic                       ready;
   logic [xru_pkg::WORD_W-1:0] seed;

   modport source (output valid, output seed, input ready);
   modport sink (input valid, input seed, output ready);
endinterface

// ===== rtl/core/xru_mixer.sv =====
// Splitmix64 finalizer with a digit-serial constant multiplier.
module xru_mixer #(
   parameter int MUL_DIGIT_W = xru_pkg::MUL_DIGIT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [xru_pkg::WORD_W-1:0] mix_in,
   output logic                       done,
   output logic [xru_pkg::WORD_W-1:0] mix_out
);

   localparam int W     = xru_pkg::WORD_W;
   localparam int STEPS = W / MUL_DIGIT_W;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_MUL1 = 3'd1;
   localparam logic [2:0] M_XS   = 3'd2;
   localparam logic [2:0] M_MUL2 = 3'd3;
   localparam logic [2:0] M_FIN  = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [W-1:0]               mcand_ff, mcand_in;
   logic [W-1:0]               k_ff, k_in;
   logic [W-1:0]               acc_ff, acc_in;
   logic [W-1:0]               res_ff, res_in;
   logic [W+MUL_DIGIT_W-1:0]   partial;

   always_comb begin
      partial  = mcand_ff * k_ff[MUL_DIGIT_W-1:0];
      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               mcand_in = mix_in ^ (mix_in >> xru_pkg::MIX_SHR_1);
               k_in     = xru_pkg::MIX_MUL_1;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = M_MUL1;
            end
         end
         M_MUL1, M_MUL2: begin
            acc_in   = acc_ff + partial[W-1:0];
            mcand_in = mcand_ff << MUL_DIGIT_W;
            k_in     = k_ff >> MUL_DIGIT_W;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = (state_ff == M_MUL1) ? M_XS : M_FIN;
            end
         end
         M_XS: begin
            mcand_in = acc_ff ^ (acc_ff >> xru_pkg::MIX_SHR_2);
            k_in     = xru_pkg::MIX_MUL_2;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = M_MUL2;
         end
         M_FIN: begin
            res_in   = acc_ff ^ (acc_ff >> xru_pkg::MIX_SHR_3);
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
   end

   assign done    = done_ff;
   assign mix_out = res_ff;

endmodule

// ===== rtl/core/xru_divider.sv =====
// Bit-serial restoring divider that yields the remainder of a 64-bit division.
module xru_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [xru_pkg::WORD_W-1:0] dividend,
   input  logic [xru_pkg::WORD_W-1:0] divisor,
   output logic                       done,
   output logic [xru_pkg::WORD_W-1:0] remainder
);

   localparam int W     = xru_pkg::WORD_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     dvd_ff, dvd_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W:0]       trial;
   logic [W:0]       diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = diff[W] ? trial[W-1:0] : diff[W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/xru_gen.sv =====
// Xorshift128+ state words and the registered draw.
module xru_gen (
   input  logic                       clock,
   input  xru_pkg::gen_ctrl_type      ctrl,
   input  logic [xru_pkg::WORD_W-1:0] load_value,
   output logic [xru_pkg::WORD_W-1:0] draw_value
);

   localparam int W = xru_pkg::WORD_W;

   logic [W-1:0] state_a_ff, state_a_in;
   logic [W-1:0] state_b_ff, state_b_in;
   logic [W-1:0] draw_ff, draw_in;
   logic [W-1:0] t1;
   logic [W-1:0] t2;
   logic [W-1:0] t3;

   always_comb begin
      t1         = state_a_ff ^ (state_a_ff << xru_pkg::XS_SHL);
      t2         = t1 ^ (t1 >> xru_pkg::XS_SHR_1);
      t3         = t2 ^ state_b_ff ^ (state_b_ff >> xru_pkg::XS_SHR_2);
      state_a_in = state_a_ff;
      state_b_in = state_b_ff;
      draw_in    = draw_ff;
      if (ctrl.step) begin
         state_a_in = state_b_ff;
         state_b_in = t3;
         draw_in    = t3 + state_b_ff;
      end
      if (ctrl.load_a) begin
         state_a_in = load_value;
      end
      if (ctrl.load_b) begin
         state_b_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      state_a_ff <= state_a_in;
      state_b_ff <= state_b_in;
      draw_ff    <= draw_in;
   end

   assign draw_value = draw_ff;

endmodule

// ===== rtl/core/xorshift128plus_random_unit_top.sv =====
// Top level of the xorshift128+ random unit with splitmix64 seeding.
// Requests arrive on req_if, one opcode and its operands per beat, and each
// request returns exactly one beat on rsp_if. The seed register is written on
// csr_if; a write reloads both generator words, as does reset with seed 1.
// Seeding runs two splitmix64 finalizers on a digit-serial multiplier, and
// no request is taken until it finishes. One request is worked on at a time.
// Raw, fraction, bit and drawing chance requests are decoded, step the
// generator once and load the response; empty ranges, chances that need no
// draw and unused opcodes go from decode straight to the response, and the
// identifier steps the generator twice. Nonempty range requests also wait on
// the bit-serial remainder unit that resolves one quotient bit per cycle over
// all 64 bits. The next request can be taken in the cycle after a response is
// loaded, unless a seed write is pending.
// The response sits in an output register, so a new request is taken while
// an earlier response still waits; a finished result then waits until that
// register is free. Stalling the receiver never drops or repeats a result.
`include "xorshift128plus_random_unit_top_defines.svh"
module xorshift128plus_random_unit_top #(
   parameter int MUL_DIGIT_W = xru_pkg::MUL_DIGIT_W
) (
   input  logic       clock,
   input  logic       reset,
   xru_csr_if.sink    csr_if,
   xru_req_if.sink    req_if,
   xru_rsp_if.source  rsp_if
);

   localparam int W  = xru_pkg::WORD_W;
   localparam int HW = xru_pkg::HALF_W;

   localparam logic [3:0] S_MIX_A_GO   = 4'd0;
   localparam logic [3:0] S_MIX_A_WAIT = 4'd1;
   localparam logic [3:0] S_MIX_B_GO   = 4'd2;
   localparam logic [3:0] S_MIX_B_WAIT = 4'd3;
   localparam logic [3:0] S_IDLE       = 4'd4;
   localparam logic [3:0] S_DECODE     = 4'd5;
   localparam logic [3:0] S_DRAW       = 4'd6;
   localparam logic [3:0] S_USE        = 4'd7;
   localparam logic [3:0] S_DIV        = 4'd8;
   localparam logic [3:0] S_EMIT       = 4'd9;

   function automatic logic [W-1:0] fit_range(input logic [W-1:0] v, input logic narrow,
                                              input logic sgn);
      logic [W-1:0] r;
      if (!narrow) begin
         r = v;
      end else if (sgn) begin
         r = {{(W-HW){v[HW-1]}}, v[HW-1:0]};
      end else begin
         r = {{(W-HW){1'b0}}, v[HW-1:0]};
      end
      return r;
   endfunction

   logic [3:0]                   state_ff, state_in;
   logic [W-1:0]                 seed_ff, seed_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                 rsp_value_ff, rsp_value_in;
   logic                         second_ff, second_in;
   logic [xru_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [W-1:0]                 lo_ff, lo_in;
   logic [W-1:0]                 hi_ff, hi_in;
   logic [xru_pkg::PROB_W-1:0]   prob_ff, prob_in;
   logic [W-1:0]                 res_ff, res_in;
   logic [W-1:0]                 divisor_ff, divisor_in;
   logic                         narrow_ff, narrow_in;
   logic                         sign_ff, sign_in;
   logic [W-1:0]                 first_ff, first_in;

   logic                         req_take;
   logic                         csr_take;
   logic                         mix_waiting;
   logic                         narrow;
   logic                         sgn;
   logic [W-1:0]                 a_ext;
   logic [W-1:0]                 b_ext;
   logic [W-1:0]                 bias;
   logic                         empty;
   logic [W-1:0]                 span;
   logic [W-1:0]                 lo_fit;
   logic [xru_pkg::PROB_W-1:0]   frac;

   logic                         mix_start;
   logic [W-1:0]                 mix_in;
   logic                         mix_done;
   logic [W-1:0]                 mix_out;
   logic                         div_start;
   logic [W-1:0]                 div_dividend;
   logic                         div_done;
   logic [W-1:0]                 div_rem;
   xru_pkg::gen_ctrl_type        gen_ctrl;
   logic [W-1:0]                 draw_value;

   assign csr_if.ready = (state_ff == S_IDLE);
   assign req_if.ready = (state_ff == S_IDLE) && !csr_if.valid;
   assign csr_take     = csr_if.valid && csr_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign mix_waiting  = (state_ff == S_MIX_A_WAIT) || (state_ff == S_MIX_B_WAIT);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.value = rsp_value_ff;

   always_comb begin
      narrow = (op_ff inside {xru_pkg::OP_RANGE_U32, xru_pkg::OP_RANGE_I32});
      sgn    = (op_ff inside {xru_pkg::OP_RANGE_I32, xru_pkg::OP_RANGE_I64});
      a_ext  = narrow ? {{(W-HW){1'b0}}, lo_ff[HW-1:0]} : lo_ff;
      b_ext  = narrow ? {{(W-HW){1'b0}}, hi_ff[HW-1:0]} : hi_ff;
      bias   = '0;
      if (sgn) begin
         if (narrow) begin
            bias[HW-1] = 1'b1;
         end else begin
            bias[W-1] = 1'b1;
         end
      end
      empty  = (a_ext ^ bias) >= (b_ext ^ bias);
      span   = b_ext - a_ext;
      lo_fit = fit_range(lo_ff, narrow, sgn);
      frac   = xru_pkg::PROB_W'(draw_value >> xru_pkg::FRAC_SHR);
   end

   always_comb begin
      state_in        = state_ff;
      seed_in         = seed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in    = rsp_value_ff;
      second_in       = second_ff;
      op_in           = op_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      prob_in         = prob_ff;
      res_in          = res_ff;
      divisor_in      = divisor_ff;
      narrow_in       = narrow_ff;
      sign_in         = sign_ff;
      first_in        = first_ff;
      mix_start       = 1'b0;
      mix_in          = seed_ff + xru_pkg::GOLDEN_GAMMA;
      div_start       = 1'b0;
      div_dividend    = narrow_ff ? {{(W-HW){1'b0}}, draw_value[HW-1:0]} : draw_value;
      gen_ctrl.step   = 1'b0;
      gen_ctrl.load_a = 1'b0;
      gen_ctrl.load_b = 1'b0;
      case (state_ff)
         S_MIX_A_GO: begin
            mix_start = 1'b1;
            state_in  = S_MIX_A_WAIT;
         end
         S_MIX_A_WAIT: begin
            if (mix_done) begin
               gen_ctrl.load_a = 1'b1;
               state_in        = S_MIX_B_GO;
            end
         end
         S_MIX_B_GO: begin
            mix_start = 1'b1;
            mix_in    = seed_ff + xru_pkg::GOLDEN_GAMMA_2;
            state_in  = S_MIX_B_WAIT;
         end
         S_MIX_B_WAIT: begin
            if (mix_done) begin
               gen_ctrl.load_b = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_IDLE: begin
            if (csr_take) begin
               seed_in  = csr_if.seed;
               state_in = S_MIX_A_GO;
            end else if (req_take) begin
               op_in    = req_if.opcode;
               lo_in    = req_if.low_bound;
               hi_in    = req_if.high_bound;
               prob_in  = req_if.probability;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            second_in  = 1'b0;
            narrow_in  = narrow;
            sign_in    = sgn;
            divisor_in = narrow ? {{(W-HW){1'b0}}, span[HW-1:0]} : span;
            case (op_ff)
               xru_pkg::OP_RAW, xru_pkg::OP_FRACTION, xru_pkg::OP_IDENT,
               xru_pkg::OP_BIT: begin
                  state_in = S_DRAW;
               end
               xru_pkg::OP_RANGE_U32, xru_pkg::OP_RANGE_U64, xru_pkg::OP_RANGE_I32,
               xru_pkg::OP_RANGE_I64: begin
                  if (empty) begin
                     res_in   = lo_fit;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_DRAW;
                  end
               end
               xru_pkg::OP_CHANCE: begin
                  if (prob_ff == '0) begin
                     res_in   = '0;
                     state_in = S_EMIT;
                  end else if (prob_ff[xru_pkg::PROB_W-1]) begin
                     res_in   = W'(1);
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_DRAW;
                  end
               end
               default: begin
                  res_in   = '0;
                  state_in = S_EMIT;
               end
            endcase
         end
         S_DRAW: begin
            gen_ctrl.step = 1'b1;
            state_in      = S_USE;
         end
         S_USE: begin
            state_in = S_EMIT;
            case (op_ff)
               xru_pkg::OP_RAW: begin
                  res_in = draw_value;
               end
               xru_pkg::OP_FRACTION: begin
                  res_in = draw_value >> xru_pkg::FRAC_SHR;
               end
               xru_pkg::OP_BIT: begin
                  res_in = {{(W-1){1'b0}}, draw_value[0]};
               end
               xru_pkg::OP_CHANCE: begin
                  res_in = {{(W-1){1'b0}}, (frac < prob_ff)};
               end
               xru_pkg::OP_IDENT: begin
                  if (!second_ff) begin
                     first_in  = draw_value;
                     second_in = 1'b1;
                     state_in  = S_DRAW;
                  end else begin
                     res_in = {first_ff[HW-1:0], draw_value[W-1:HW]};
                  end
               end
               xru_pkg::OP_RANGE_U32, xru_pkg::OP_RANGE_U64, xru_pkg::OP_RANGE_I32,
               xru_pkg::OP_RANGE_I64: begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = fit_range(a_ext + div_rem, narrow_ff, sign_ff);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_MIX_A_GO;
         seed_ff      <= xru_pkg::SEED_RESET;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      op_ff        <= op_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      prob_ff      <= prob_in;
      res_ff       <= res_in;
      divisor_ff   <= divisor_in;
      narrow_ff    <= narrow_in;
      sign_ff      <= sign_in;
      first_ff     <= first_in;
   end

   xru_mixer #(
      .MUL_DIGIT_W (MUL_DIGIT_W)
   ) u_mixer (
      .clock   (clock),
      .reset   (reset),
      .start   (mix_start),
      .mix_in  (mix_in),
      .done    (mix_done),
      .mix_out (mix_out)
   );

   xru_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (divisor_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   xru_gen u_gen (
      .clock      (clock),
      .ctrl       (gen_ctrl),
      .load_value (mix_out),
      .draw_value (draw_value)
   );

   `XRU_ASSERT_IMP(a_req_not_with_csr, clock, reset, req_take, !csr_take)
   `XRU_ASSERT_NEXT(a_req_goes_decode, clock, reset, req_take, state_ff == S_DECODE)
   `XRU_ASSERT_IMP(a_mix_done_when_seeding, clock, reset, mix_done, mix_waiting)
   `XRU_ASSERT_IMP(a_div_done_when_dividing, clock, reset, div_done, state_ff == S_DIV)
   `XRU_ASSERT_NEXT(a_emit_loads_output, clock, reset, (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_if.ready), rsp_valid_ff)

endmodule
